### hdl/fso_pkg.sv
// package: types and constants for the factor sum-out block
package fso_pkg;

    localparam int MAX_VARS   = 8;
    localparam int VALUE_BITS = 4;
    localparam int MAX_ROWS   = 64;

    localparam int VAR_IDX_W  = $clog2(MAX_VARS);
    localparam int VAR_CNT_W  = $clog2(MAX_VARS + 1);
    localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
    localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);

    localparam logic [1:0] FUNC_ADD_VAR = 2'd0;
    localparam logic [1:0] FUNC_ADD_ROW = 2'd1;
    localparam logic [1:0] FUNC_SUM_OUT = 2'd2;
    localparam logic [1:0] FUNC_CLEAR   = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] var_id;
        logic [31:0] tuple_in;
        logic [31:0] potential_in;
    } fso_in_t;

    typedef struct packed {
        logic        found;
        logic        row_valid;
        logic [31:0] tuple_out;
        logic [31:0] potential_out;
        logic        overflow;
        logic        last;
    } fso_out_t;

    // remove one slot from a packed tuple
    function automatic logic [31:0] drop_slot(input logic [31:0] t,
                                              input logic [VAR_IDX_W-1:0] slot);
        logic [31:0] lo_mask;
        logic [31:0] high;
        int          lo_bits;
        lo_bits = int'(slot) * VALUE_BITS;
        lo_mask = (lo_bits >= 32) ? '1 : ((32'd1 << lo_bits) - 32'd1);
        high    = (lo_bits + VALUE_BITS < 32) ? ((t >> (lo_bits + VALUE_BITS)) << lo_bits) : '0;
        return (t & lo_mask) | high;
    endfunction

    function automatic logic [31:0] keep_mask(input logic [VAR_CNT_W-1:0] cnt);
        int bits;
        bits = int'(cnt) * VALUE_BITS;
        return (bits >= 32) ? '1 : ((32'd1 << bits) - 32'd1);
    endfunction

endpackage

### hdl/factor_sum_out_top.sv
// top level: factor table with sum-out of a variable
// usage:
//   input channel (in_valid/in_ready/in_data) carries one command item:
//   append variable, append row, clear, or sum out a variable.
//   output channel (out_valid/out_ready/out_data) carries result items;
//   only a sum-out makes results (one per merged row, last flagged, or a
//   single item with row_valid=0).
// sequence:
//   loads and clear are handled in the idle state. a variable search checks
//   one variable per step, then shifts one variable per step from the match
//   to the end of the list to close the gap. a sum-out then walks every
//   stored row (i): read and wait states to read it, plus read and compare
//   states for each merged row (j) it is checked against; then a read and
//   an emit state per emitted row plus any stall time. every row access
//   goes through the single row memory read port.
// reset:
//   rst_n clears counts, overflow flag and control; the memories hold
//   garbage until written and only entries below the counts are read.
// stall:
//   out_ready low holds the emit walk; the output register holds its item.
module factor_sum_out_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fso_pkg::fso_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output fso_pkg::fso_out_t out_data
);
    import fso_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SRCH   = 10'b0000000010,
        S_SHIFT  = 10'b0000000100,
        S_RDI    = 10'b0000001000,
        S_WAITI  = 10'b0000010000,
        S_RDJ    = 10'b0000100000,
        S_CMPJ   = 10'b0001000000,
        S_EMITRD = 10'b0010000000,
        S_EMIT   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // variable list: small, read at one address
    logic [15:0] var_mem [MAX_VARS];
    // row memory: tuple and potential in one word
    logic [63:0] row_mem [MAX_ROWS];
    logic [63:0] row_rd;
    logic [ROW_IDX_W-1:0] rd_addr;
    logic        rd_en;
    logic [ROW_IDX_W-1:0] wr_addr;
    logic [63:0] wr_data;
    logic        wr_en;

    logic [VAR_CNT_W-1:0] var_cnt_reg;
    logic [ROW_CNT_W-1:0] row_cnt_reg;
    logic                 ovf_reg;
    logic [15:0]          vid_reg;
    logic [VAR_CNT_W-1:0] pos_reg;     // search / shift index
    logic [VAR_IDX_W-1:0] slot_reg;
    logic [ROW_CNT_W-1:0] i_reg, j_reg, merged_reg;
    logic [31:0]          t_reg, p_reg;
    logic [31:0]          keep_reg;

    logic       ov_reg;
    fso_out_t   od_reg;

    logic in_fire;
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    logic out_free;
    assign out_free = !ov_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            row_mem[wr_addr] <= wr_data;
        if (rd_en)
            row_rd <= row_mem[rd_addr];
    end

    logic [15:0] var_rd;
    assign var_rd = var_mem[pos_reg[VAR_IDX_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.func == FUNC_ADD_VAR && var_cnt_reg < VAR_CNT_W'(MAX_VARS))
            var_mem[var_cnt_reg[VAR_IDX_W-1:0]] <= in_data.var_id;
        else if (state_reg == S_SHIFT && pos_reg + 1'b1 < var_cnt_reg)
            var_mem[pos_reg[VAR_IDX_W-1:0]] <= var_mem[VAR_IDX_W'(pos_reg + 1'b1)];
    end

    // memory port control
    logic [31:0] t_new;
    assign t_new = drop_slot(row_rd[63:32], slot_reg) & keep_reg;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_data.func == FUNC_ADD_ROW
                    && row_cnt_reg < ROW_CNT_W'(MAX_ROWS))
                begin
                    wr_en   = 1'b1;
                    wr_addr = row_cnt_reg[ROW_IDX_W-1:0];
                    wr_data = {in_data.tuple_in, in_data.potential_in};
                end
            end
            S_RDI:    begin rd_en = 1'b1; rd_addr = i_reg[ROW_IDX_W-1:0]; end
            S_RDJ:    begin rd_en = 1'b1; rd_addr = j_reg[ROW_IDX_W-1:0]; end
            S_EMITRD: begin rd_en = 1'b1; rd_addr = i_reg[ROW_IDX_W-1:0]; end
            S_CMPJ:
            begin
                if (row_rd[63:32] == t_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = j_reg[ROW_IDX_W-1:0];
                    wr_data = {t_reg, ({1'b0, row_rd[31:0]} + {1'b0, p_reg} > 33'hFFFFFFFF)
                               ? 32'hFFFFFFFF : row_rd[31:0] + p_reg};
                end
                else if (j_reg + 1'b1 >= merged_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = merged_reg[ROW_IDX_W-1:0];
                    wr_data = {t_reg, p_reg};
                end
            end
            S_WAITI:
            begin
                if (merged_reg == '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = {t_new, row_rd[31:0]};
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_fire && in_data.func == FUNC_SUM_OUT) state_next = S_SRCH;
            S_SRCH:
            begin
                if (pos_reg >= var_cnt_reg) state_next = S_DONE;
                else if (var_rd == vid_reg) state_next = S_SHIFT;
            end
            S_SHIFT:  if (pos_reg + 1'b1 >= var_cnt_reg)
                          state_next = (row_cnt_reg == '0) ? S_DONE : S_RDI;
            S_RDI:    state_next = S_WAITI;
            S_WAITI:
            begin
                if (merged_reg == '0)
                    state_next = (i_reg + 1'b1 >= row_cnt_reg) ? S_EMITRD : S_RDI;
                else
                    state_next = S_RDJ;
            end
            S_RDJ:    state_next = S_CMPJ;
            S_CMPJ:
            begin
                if (row_rd[63:32] == t_reg || j_reg + 1'b1 >= merged_reg)
                    state_next = (i_reg + 1'b1 >= row_cnt_reg) ? S_EMITRD : S_RDI;
                else
                    state_next = S_RDJ;
            end
            S_EMITRD: if (out_free) state_next = S_EMIT;
            S_EMIT:   state_next = (i_reg >= merged_reg) ? S_IDLE : S_EMITRD;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    logic found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            var_cnt_reg <= '0;
            row_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
            ov_reg      <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // the done state reloads the output register itself
            if (ov_reg && out_ready && state_reg != S_DONE)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        vid_reg <= in_data.var_id;
                        pos_reg <= '0;
                        found_reg <= 1'b0;
                        case (in_data.func)
                            FUNC_ADD_VAR:
                                if (var_cnt_reg < VAR_CNT_W'(MAX_VARS))
                                    var_cnt_reg <= var_cnt_reg + 1'b1;
                                else
                                    ovf_reg <= 1'b1;
                            FUNC_ADD_ROW:
                                if (row_cnt_reg < ROW_CNT_W'(MAX_ROWS))
                                    row_cnt_reg <= row_cnt_reg + 1'b1;
                                else
                                    ovf_reg <= 1'b1;
                            FUNC_CLEAR:
                            begin
                                var_cnt_reg <= '0;
                                row_cnt_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SRCH:
                    if (pos_reg < var_cnt_reg)
                    begin
                        if (var_rd == vid_reg)
                        begin
                            found_reg <= 1'b1;
                            slot_reg  <= pos_reg[VAR_IDX_W-1:0];
                        end
                        else
                            pos_reg <= pos_reg + 1'b1;
                    end
                S_SHIFT:
                begin
                    if (pos_reg + 1'b1 >= var_cnt_reg)
                    begin
                        var_cnt_reg <= var_cnt_reg - 1'b1;
                        keep_reg    <= keep_mask(var_cnt_reg - 1'b1);
                        i_reg       <= '0;
                        merged_reg  <= '0;
                    end
                    else
                        pos_reg <= pos_reg + 1'b1;
                end
                S_WAITI:
                begin
                    t_reg <= t_new;
                    p_reg <= row_rd[31:0];
                    j_reg <= '0;
                    if (merged_reg == '0)
                    begin
                        merged_reg <= ROW_CNT_W'(1);
                        if (i_reg + 1'b1 >= row_cnt_reg)
                        begin
                            row_cnt_reg <= ROW_CNT_W'(1);
                            i_reg       <= '0;
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                end
                S_CMPJ:
                begin
                    if (row_rd[63:32] == t_reg || j_reg + 1'b1 >= merged_reg)
                    begin
                        logic [ROW_CNT_W-1:0] m_next;
                        m_next = (row_rd[63:32] == t_reg) ? merged_reg : merged_reg + 1'b1;
                        merged_reg <= m_next;
                        if (i_reg + 1'b1 >= row_cnt_reg)
                        begin
                            row_cnt_reg <= m_next;
                            i_reg       <= '0;
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
                S_EMITRD:
                    if (out_free)
                        i_reg <= i_reg + 1'b1;
                S_EMIT:
                begin
                    ov_reg <= 1'b1;
                    od_reg <= '{found: 1'b1, row_valid: 1'b1,
                                tuple_out: row_rd[63:32], potential_out: row_rd[31:0],
                                overflow: ovf_reg, last: (i_reg >= merged_reg)};
                end
                S_DONE:
                    if (out_free)
                    begin
                        ov_reg <= 1'b1;
                        od_reg <= '{found: found_reg, row_valid: 1'b0, tuple_out: '0,
                                    potential_out: '0, overflow: ovf_reg, last: 1'b1};
                        if (found_reg)
                            var_cnt_reg <= var_cnt_reg;
                    end
                default: ;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

### hdl/fso_checker.sv
// checker: port-level assertions for the factor sum-out block, with bind
module fso_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input fso_pkg::fso_out_t out_data
);
    import fso_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    a_norow_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.row_valid |-> out_data.last)
        else $error("rowless result not last");

    a_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> !out_data.row_valid)
        else $error("row given for absent variable");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !in_ready)
        else $error("input taken mid sum-out");

endmodule

bind factor_sum_out_top fso_checker u_fso_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
